FILE: hw/rtl/mrfft_pkg.sv
// Shared types, constants and the quarter-wave twiddle table for the mixed radix-4 FFT.
// Used by mrfft_mac, mrfft_engine and mixed_radix4_complex_fft. No dependencies.
package mrfft_pkg;

	localparam int POINTS = 512;
	localparam int LP     = $clog2(POINTS);
	localparam int AW     = LP;
	localparam int NW     = AW + 1;
	localparam int SZW    = 4;
	localparam int BIN_W  = 9;
	localparam int SW     = 16;
	localparam int TW     = 16;
	localparam int DW     = 28;
	localparam int Q4     = POINTS / 4;
	localparam int P8     = Q4 / 2;
	localparam int PW     = DW + TW + 1;
	localparam int ACW    = PW + 1;
	localparam int RW     = ACW - (TW - 1);

	localparam logic REG_INVERSE = 1'b0;
	localparam logic REG_SIZE    = 1'b1;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_FRAME  = 2'd1,
		ST_BIN    = 2'd2,
		ST_NONE   = 2'd3
	} status_t;

	typedef struct packed {
		logic                 mode;
		logic signed [SW-1:0] sample_real;
		logic signed [SW-1:0] sample_imag;
		logic [BIN_W-1:0]     bin_index;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic signed [DW-1:0] bin_real;
		logic signed [DW-1:0] bin_imag;
	} rsp_t;

	typedef struct packed {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
	} cplx_t;

	typedef struct packed {
		logic           start;
		logic           inv;
		logic [SZW-1:0] size;
		logic           wr;
		logic [AW-1:0]  addr;
		cplx_t          wdata;
	} eng_ctl_t;

	typedef struct packed {
		logic  done;
		logic  busy;
		cplx_t rdata;
	} eng_sts_t;

	typedef struct packed {
		logic                 issue;
		logic                 clr;
		logic                 sub;
		logic signed [DW-1:0] a;
		logic signed [TW:0]   w;
	} mac_ctl_t;

	typedef logic [TW-1:0] qtab_t [0:Q4];

	// shift-subtract quotient of two non-negative values, elaboration only
	function automatic longint udiv(input longint num, input longint den);
		longint q, r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((num >>> b) & 64'sd1);
			if (r >= den) begin
				r = r - den;
				q = q | (64'sd1 <<< b);
			end
		end
		return q;
	endfunction

	// cos(2*pi*k/P) magnitudes, built with a Q31 Taylor series at elaboration
	function automatic qtab_t build_qtab();
		qtab_t  t;
		longint x, x2, term, sum, d, num;
		int     a;
		bit     want_sin;
		for (int k = 0; k <= Q4; k++) begin
			a        = (k <= P8) ? k : Q4 - k;
			want_sin = (k > P8);
			num      = longint'(a) * 64'sd13493037705 + (64'sd1 <<< (LP - 1));
			x        = num >>> LP;
			x2       = (x * x + (64'sd1 <<< 30)) >>> 31;
			term     = want_sin ? x : (64'sd1 <<< 31);
			sum      = term;
			for (int n = 1; n <= 10; n++) begin
				d    = want_sin ? longint'((2 * n) * (2 * n + 1)) :
					longint'((2 * n - 1) * (2 * n));
				term = udiv((term * x2 + (64'sd1 <<< 30)) >>> 31, d);
				sum  = ((n & 1) != 0) ? sum - term : sum + term;
			end
			t[k] = TW'((sum + (64'sd1 <<< (32 - TW - 1))) >>> (32 - TW));
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

endpackage

FILE: hw/rtl/mixed_radix4_complex_fft.sv
// Top level of the mixed radix-4 complex FFT: handshakes, registers, frame loading, bin readout.
// Depends on mrfft_pkg and mrfft_engine.
//
//   port group   dir  handshake             payload
//   req          in   req_valid/req_stall   mode, sample_real, sample_imag, bin_index
//   rsp          out  rsp_valid/rsp_stall   status, bin_real, bin_imag
//   cfg          in   cfg_we                cfg_index, cfg_data
//
// A bin read passes through the registered read of the single-port frame memory and
// the output register; a load response comes from the output register alone. The last
// sample of a frame starts the transform: bit reversal (with conjugation when inverse),
// radix-4 butterflies, a radix-2 pass for odd sizes and inverse scaling, all through the one
// shared multiplier and the one memory port. Reset clears control state only; the frame
// memory is undefined until written. While busy or holding a result req_stall stays high.
module mixed_radix4_complex_fft (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mrfft_pkg::req_t      req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output mrfft_pkg::rsp_t      rsp,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [3:0]           cfg_data
);
	import mrfft_pkg::*;

	typedef enum logic [2:0] {
		T_IDLE  = 3'b001,
		T_READ  = 3'b010,
		T_XFORM = 3'b100
	} tst_t;

	tst_t           st_q;
	logic           inverse_q;
	logic [SZW-1:0] size_q;
	logic [AW-1:0]  load_count_q;
	logic           result_ready_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	eng_ctl_t       eng_ctl;
	eng_sts_t       eng_sts;

	logic           accept;
	logic [AW-1:0]  n_mask;
	logic [AW-1:0]  ld_idx;
	logic           last;
	logic [SZW-1:0] size_clamped;

	// one item at a time: hold off while working or while a result waits
	assign req_stall = (st_q != T_IDLE) || rsp_valid_q || eng_sts.busy;
	assign accept    = req_valid && !req_stall;
	assign n_mask    = AW'((NW'(1) << size_q) - NW'(1));
	assign ld_idx    = load_count_q & n_mask;
	assign last      = (ld_idx == n_mask);

	always_comb begin
		size_clamped = cfg_data;
		if (cfg_data == '0) size_clamped = SZW'(1);
		else if (cfg_data > SZW'(LP)) size_clamped = SZW'(LP);
	end

	always_comb begin
		eng_ctl.start    = accept && !req.mode && last;
		eng_ctl.inv      = inverse_q;
		eng_ctl.size     = size_q;
		eng_ctl.wr       = accept && !req.mode;
		eng_ctl.addr     = req.mode ? (AW'(req.bin_index) & n_mask) : ld_idx;
		eng_ctl.wdata.re = DW'(req.sample_real);
		eng_ctl.wdata.im = DW'(req.sample_imag);
	end

	mrfft_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (eng_ctl),
		.sts    (eng_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= T_IDLE;
			inverse_q      <= 1'b0;
			size_q         <= SZW'(LP < 9 ? LP : 9);
			load_count_q   <= '0;
			result_ready_q <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			// drop the result once its transfer completes
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_INVERSE: inverse_q <= cfg_data[0];
					REG_SIZE: begin
						size_q         <= size_clamped;
						load_count_q   <= '0;
						result_ready_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end

			unique case (st_q)
				T_IDLE: begin
					if (accept) begin
						if (!req.mode) begin
							result_ready_q <= 1'b0;
							if (last) begin
								load_count_q <= '0;
								st_q         <= T_XFORM;
							end else begin
								load_count_q <= ld_idx + AW'(1);
								rsp_valid_q  <= 1'b1;
							end
						end else if (result_ready_q) begin
							st_q <= T_READ;
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end
				end
				T_READ: begin
					rsp_valid_q <= 1'b1;
					st_q        <= T_IDLE;
				end
				T_XFORM: begin
					if (eng_sts.done) begin
						result_ready_q <= 1'b1;
						rsp_valid_q    <= 1'b1;
						st_q           <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	// result payload: advance only when a new result is formed
	always_ff @(posedge clk) begin
		unique case (st_q)
			T_IDLE: begin
				if (accept) begin
					rsp_q.bin_real <= '0;
					rsp_q.bin_imag <= '0;
					rsp_q.status   <= req.mode ? ST_NONE : ST_STORED;
				end
			end
			T_READ: begin
				rsp_q.status   <= ST_BIN;
				rsp_q.bin_real <= eng_sts.rdata.re;
				rsp_q.bin_imag <= eng_sts.rdata.im;
			end
			T_XFORM: begin
				if (eng_sts.done) begin
					rsp_q.status   <= ST_FRAME;
					rsp_q.bin_real <= '0;
					rsp_q.bin_imag <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hw/rtl/mrfft_mac.sv
// Shared multiply-accumulate unit: one registered multiplier, one accumulator.
// Depends on mrfft_pkg.
module mrfft_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mrfft_pkg::mac_ctl_t             ctl,
	output logic signed [mrfft_pkg::ACW-1:0] acc
);
	import mrfft_pkg::*;

	logic                  vld_s1;
	logic                  clr_s1;
	logic                  sub_s1;
	logic signed [PW-1:0]  prod_s1;
	logic signed [ACW-1:0] acc_q;
	logic signed [ACW-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ctl.a * ctl.w;
		clr_s1  <= ctl.clr;
		sub_s1  <= ctl.sub;
		if (vld_s1) begin
			acc_q <= sub_s1 ? base - ACW'(prod_s1) : base + ACW'(prod_s1);
		end
	end

	assign base = clr_s1 ? '0 : acc_q;
	assign acc  = acc_q;

endmodule

FILE: hw/rtl/mrfft_engine.sv
// Frame memory and transform sequencer: bit reversal, radix-4 and radix-2 passes, scaling.
// Depends on mrfft_pkg and mrfft_mac.
module mrfft_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  mrfft_pkg::eng_ctl_t ctl,
	output mrfft_pkg::eng_sts_t sts
);
	import mrfft_pkg::*;

	localparam int CBW = RW + 2;
	localparam int YW  = CBW + 1;
	localparam logic signed [YW-1:0]  DMAX = YW'((64'sd1 <<< (DW - 1)) - 1);
	localparam logic signed [YW-1:0]  DMIN = -DMAX - YW'(1);
	localparam logic signed [ACW-1:0] HALF = ACW'(64'sd1 <<< (TW - 2));

	typedef enum logic [7:0] {
		E_IDLE  = 8'b0000_0001,
		E_SETUP = 8'b0000_0010,
		E_FETCH = 8'b0000_0100,
		E_MUL   = 8'b0000_1000,
		E_COMB1 = 8'b0001_0000,
		E_COMB2 = 8'b0010_0000,
		E_STORE = 8'b0100_0000,
		E_NEXT  = 8'b1000_0000
	} est_t;

	typedef enum logic [3:0] {
		PS_BREV  = 4'b0001,
		PS_R4    = 4'b0010,
		PS_R2    = 4'b0100,
		PS_SCALE = 4'b1000
	} pass_t;

	function automatic logic signed [DW-1:0] sat(input logic signed [YW-1:0] v);
		if (v > DMAX) return DMAX[DW-1:0];
		if (v < DMIN) return DMIN[DW-1:0];
		return v[DW-1:0];
	endfunction

	function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
		logic [AW-1:0] r;
		for (int k = 0; k < AW; k++) r[k] = v[AW-1-k];
		return r;
	endfunction

	cplx_t mem [0:POINTS-1];
	cplx_t rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	cplx_t         mem_wdata;

	est_t           st_q;
	pass_t          pass_q;
	logic [SZW-1:0] l_q;
	logic [SZW-1:0] lg_q;
	logic           inv_q;
	logic           done_q;
	logic [NW-1:0]  idx_q;
	logic [2:0]     m_q;
	logic [2:0]     k_q;
	logic [3:0]     c_q;
	logic [AW-1:0]  e_q;
	logic [AW-1:0]  addr_q [0:3];
	cplx_t          x_q [0:3];
	cplx_t          y_q [0:3];
	logic signed [RW-1:0]  tr_q [1:3];
	logic signed [RW-1:0]  ti_q [1:3];
	logic signed [CBW-1:0] t_re_q [0:3];
	logic signed [CBW-1:0] t_im_q [0:3];

	// job setup
	logic [NW-1:0] n_pts;
	logic [NW-1:0] lim;
	logic [AW-1:0] b_idx, rv, r4_span, r4_j, r4_i, r2_span;
	logic          skip;
	logic [AW-1:0] s_addr [0:3];
	logic [2:0]    s_m;
	logic [AW-1:0] s_e;

	assign n_pts = NW'(1) << l_q;
	assign b_idx = idx_q[AW-1:0];
	assign rv    = bit_rev(b_idx) >> (SZW'(AW) - l_q);
	assign r4_span = AW'(1) << (lg_q - SZW'(2));
	assign r4_j    = b_idx & (r4_span - AW'(1));
	assign r4_i    = ((b_idx >> (lg_q - SZW'(2))) << lg_q) | r4_j;
	assign r2_span = AW'(1) << (l_q - SZW'(1));

	always_comb begin
		skip   = 1'b0;
		s_m    = 3'd1;
		s_e    = '0;
		s_addr[0] = b_idx;
		s_addr[1] = rv;
		s_addr[2] = '0;
		s_addr[3] = '0;
		lim    = n_pts;
		unique case (pass_q)
			PS_BREV: begin
				if (b_idx < rv) s_m = 3'd2;
				else if (b_idx != rv || !inv_q) skip = 1'b1;
			end
			PS_R4: begin
				lim       = n_pts >> 2;
				s_m       = 3'd4;
				s_addr[0] = r4_i;
				s_addr[1] = r4_i + r4_span;
				s_addr[2] = r4_i + (r4_span << 1);
				s_addr[3] = r4_i + (r4_span << 1) + r4_span;
				s_e       = r4_j << (SZW'(LP) - lg_q);
			end
			PS_R2: begin
				lim       = n_pts >> 1;
				s_m       = 3'd2;
				s_addr[1] = b_idx + r2_span;
				s_e       = b_idx << (SZW'(LP) - l_q);
			end
			PS_SCALE: begin
			end
			default: begin
			end
		endcase
	end

	// twiddle and multiplier feed
	logic [3:0]    mul_lim;
	logic [1:0]    ks, cap_ks;
	logic [1:0]    q;
	logic [3:0]    pc;
	logic [AW-1:0] tw_t;
	logic [AW-2:0] tw_r;
	logic signed [TW:0] tw_c, tw_s, wr, wi;
	mac_ctl_t      mac_ctl;
	logic signed [ACW-1:0] acc;
	logic signed [ACW-1:0] acc_rnd;

	assign mul_lim = (pass_q == PS_R4) ? 4'd12 : 4'd4;
	assign ks      = c_q[3:2] + 2'd1;
	assign q       = c_q[1:0];
	assign pc      = c_q - 4'd2;
	assign cap_ks  = pc[3:2] + 2'd1;

	always_comb begin
		tw_t = e_q;
		if (pass_q == PS_R4) begin
			case (ks)
				2'd1:    tw_t = e_q << 1;
				2'd3:    tw_t = e_q + (e_q << 1);
				default: tw_t = e_q;
			endcase
		end
	end

	assign tw_r = {1'b0, tw_t[AW-3:0]};
	assign tw_c = $signed({1'b0, QTAB[tw_r]});
	assign tw_s = $signed({1'b0, QTAB[(AW-1)'(Q4) - tw_r]});

	always_comb begin
		case (tw_t[AW-1:AW-2])
			2'd0:    begin wr = tw_c;  wi = -tw_s; end
			2'd1:    begin wr = -tw_s; wi = -tw_c; end
			2'd2:    begin wr = -tw_c; wi = tw_s;  end
			default: begin wr = tw_s;  wi = tw_c;  end
		endcase
	end

	always_comb begin
		mac_ctl.issue = (st_q == E_MUL) && (c_q < mul_lim);
		mac_ctl.clr   = !q[0];
		mac_ctl.sub   = (q == 2'd1);
		mac_ctl.a     = q[0] ? x_q[ks].im : x_q[ks].re;
		mac_ctl.w     = (q == 2'd0 || q == 2'd3) ? wr : wi;
	end

	mrfft_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.acc    (acc)
	);

	assign acc_rnd = (acc + HALF) >>> (TW - 1);

	// scaling and conjugation
	logic signed [YW-1:0] half_s;
	logic signed [YW-1:0] sc_re, sc_im;
	assign half_s = YW'(1) << (l_q - SZW'(1));
	assign sc_re  = (YW'(x_q[0].re) + half_s) >>> l_q;
	assign sc_im  = (-YW'(x_q[0].im) + half_s) >>> l_q;

	function automatic cplx_t conj_if(input cplx_t v, input logic en);
		cplx_t r;
		r = v;
		if (en) r.im = sat(-YW'(v.im));
		return r;
	endfunction

	// memory port
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = addr_q[k_q[1:0]];
		mem_wdata = y_q[k_q[1:0]];
		if (st_q == E_IDLE) begin
			mem_we    = ctl.wr;
			mem_addr  = ctl.addr;
			mem_wdata = ctl.wdata;
		end else if (st_q == E_STORE) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		rd_q <= mem[mem_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= E_IDLE;
			pass_q <= PS_BREV;
			done_q <= 1'b0;
			idx_q  <= '0;
			k_q    <= '0;
			c_q    <= '0;
			lg_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					if (ctl.start) begin
						st_q   <= E_SETUP;
						pass_q <= PS_BREV;
						idx_q  <= '0;
						lg_q   <= SZW'(2);
					end
				end
				E_SETUP: begin
					k_q  <= '0;
					st_q <= skip ? E_NEXT : E_FETCH;
				end
				E_FETCH: begin
					k_q <= k_q + 3'd1;
					if (k_q == m_q) begin
						c_q  <= '0;
						st_q <= (pass_q == PS_R4 || pass_q == PS_R2) ? E_MUL : E_COMB2;
					end
				end
				E_MUL: begin
					c_q <= c_q + 4'd1;
					if (c_q == mul_lim + 4'd1) st_q <= E_COMB1;
				end
				E_COMB1: st_q <= E_COMB2;
				E_COMB2: begin
					k_q  <= '0;
					st_q <= E_STORE;
				end
				E_STORE: begin
					k_q <= k_q + 3'd1;
					if (k_q == m_q - 3'd1) st_q <= E_NEXT;
				end
				E_NEXT: begin
					st_q  <= E_SETUP;
					idx_q <= idx_q + NW'(1);
					if (idx_q + NW'(1) == lim) begin
						idx_q <= '0;
						unique case (pass_q)
							PS_BREV: pass_q <= (l_q >= SZW'(2)) ? PS_R4 : PS_R2;
							PS_R4: begin
								if (lg_q + SZW'(2) <= l_q) lg_q <= lg_q + SZW'(2);
								else if (l_q[0]) pass_q <= PS_R2;
								else if (inv_q) pass_q <= PS_SCALE;
								else begin
									st_q   <= E_IDLE;
									done_q <= 1'b1;
								end
							end
							PS_R2: begin
								if (inv_q) pass_q <= PS_SCALE;
								else begin
									st_q   <= E_IDLE;
									done_q <= 1'b1;
								end
							end
							PS_SCALE: begin
								st_q   <= E_IDLE;
								done_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == E_IDLE && ctl.start) begin
			l_q   <= ctl.size;
			inv_q <= ctl.inv;
		end
		if (st_q == E_SETUP) begin
			m_q <= s_m;
			e_q <= s_e;
			for (int k = 0; k < 4; k++) addr_q[k] <= s_addr[k];
		end
		if (st_q == E_FETCH && k_q != 3'd0) x_q[k_q[1:0] - 2'd1] <= rd_q;
		if (st_q == E_MUL && c_q >= 4'd2) begin
			if (pc[1:0] == 2'd1) tr_q[cap_ks] <= acc_rnd[RW-1:0];
			if (pc[1:0] == 2'd3) ti_q[cap_ks] <= acc_rnd[RW-1:0];
		end
		if (st_q == E_COMB1) begin
			t_re_q[0] <= CBW'(x_q[0].re) + CBW'(tr_q[1]);
			t_im_q[0] <= CBW'(x_q[0].im) + CBW'(ti_q[1]);
			t_re_q[1] <= CBW'(x_q[0].re) - CBW'(tr_q[1]);
			t_im_q[1] <= CBW'(x_q[0].im) - CBW'(ti_q[1]);
			t_re_q[2] <= CBW'(tr_q[2]) + CBW'(tr_q[3]);
			t_im_q[2] <= CBW'(ti_q[2]) + CBW'(ti_q[3]);
			t_re_q[3] <= CBW'(ti_q[2]) - CBW'(ti_q[3]);
			t_im_q[3] <= CBW'(tr_q[3]) - CBW'(tr_q[2]);
		end
		if (st_q == E_COMB2) begin
			unique case (pass_q)
				PS_BREV: begin
					y_q[0] <= conj_if((m_q == 3'd2) ? x_q[1] : x_q[0], inv_q);
					y_q[1] <= conj_if(x_q[0], inv_q);
				end
				PS_R4: begin
					y_q[0].re <= sat(YW'(t_re_q[0]) + YW'(t_re_q[2]));
					y_q[0].im <= sat(YW'(t_im_q[0]) + YW'(t_im_q[2]));
					y_q[1].re <= sat(YW'(t_re_q[1]) + YW'(t_re_q[3]));
					y_q[1].im <= sat(YW'(t_im_q[1]) + YW'(t_im_q[3]));
					y_q[2].re <= sat(YW'(t_re_q[0]) - YW'(t_re_q[2]));
					y_q[2].im <= sat(YW'(t_im_q[0]) - YW'(t_im_q[2]));
					y_q[3].re <= sat(YW'(t_re_q[1]) - YW'(t_re_q[3]));
					y_q[3].im <= sat(YW'(t_im_q[1]) - YW'(t_im_q[3]));
				end
				PS_R2: begin
					y_q[0].re <= sat(YW'(t_re_q[0]));
					y_q[0].im <= sat(YW'(t_im_q[0]));
					y_q[1].re <= sat(YW'(t_re_q[1]));
					y_q[1].im <= sat(YW'(t_im_q[1]));
				end
				PS_SCALE: begin
					y_q[0].re <= sat(sc_re);
					y_q[0].im <= sat(sc_im);
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.done  = done_q;
	assign sts.busy  = (st_q != E_IDLE);
	assign sts.rdata = rd_q;

endmodule

FILE: tb/mrfft_scoreboard.sv
// Frame-accurate FFT predictor and response checker for the mixed radix-4 FFT bench.
// Depends on mrfft_pkg for the transfer structs, status codes and register indexes.
class mrfft_scoreboard;

	longint          frame_re [0:mrfft_pkg::POINTS-1];
	longint          frame_im [0:mrfft_pkg::POINTS-1];
	longint          cos_rom  [0:mrfft_pkg::Q4];
	bit              inverse;
	int unsigned     size_log2;
	int unsigned     load_count;
	bit              bins_ready;
	mrfft_pkg::rsp_t expected_rsp [$];
	int              errors;

	function new();
		longint x, x2, term, sum, d, num;
		int     a;
		bit     want_sin;
		for (int k = 0; k <= mrfft_pkg::Q4; k++) begin
			a        = (k <= mrfft_pkg::Q4 / 2) ? k : mrfft_pkg::Q4 - k;
			want_sin = (k > mrfft_pkg::Q4 / 2);
			num      = longint'(a) * 64'sd13493037705 + 64'sd256;
			x        = num >>> 9;
			x2       = (x * x + (64'sd1 <<< 30)) >>> 31;
			term     = want_sin ? x : (64'sd1 <<< 31);
			sum      = term;
			for (int n = 1; n <= 10; n++) begin
				d    = want_sin ? longint'(2 * n * (2 * n + 1)) : longint'((2 * n - 1) * 2 * n);
				term = ((term * x2 + (64'sd1 <<< 30)) >>> 31) / d;
				sum  = (n % 2 == 1) ? sum - term : sum + term;
			end
			cos_rom[k] = (sum + 64'sd32768) >>> 16;
		end
		for (int i = 0; i < mrfft_pkg::POINTS; i++) begin
			frame_re[i] = 0;
			frame_im[i] = 0;
		end
		inverse    = 0;
		size_log2  = 9;
		load_count = 0;
		bins_ready = 0;
		errors     = 0;
	endfunction

	function longint clip(longint v);
		if (v > 64'sd134217727)
			return 64'sd134217727;
		if (v < -64'sd134217728)
			return -64'sd134217728;
		return v;
	endfunction

	// rotate (a, b) by twiddle index t of the 512-point circle, rounded to integer
	function void rotate(ref longint a, ref longint b, input int unsigned t);
		int unsigned quad, r;
		longint      c, s, wr, wi, pr, pi;
		quad = (t >> 7) & 3;
		r    = t & 127;
		c    = cos_rom[r];
		s    = cos_rom[128 - r];
		case (quad)
			0: begin wr = c;  wi = -s; end
			1: begin wr = -s; wi = -c; end
			2: begin wr = -c; wi = s;  end
			default: begin wr = s; wi = c; end
		endcase
		pr = a * wr - b * wi;
		pi = a * wi + b * wr;
		a  = (pr + 64'sd16384) >>> 15;
		b  = (pi + 64'sd16384) >>> 15;
	endfunction

	function void run_fft(int unsigned l);
		int unsigned n, rv, lg, le, q, sh;
		longint      tr, ti, r0, i0, r1, i1, r2, i2, r3, i3;
		longint      t0r, t0i, t1r, t1i, t2r, t2i, t3r, t3i;
		n = 1 << l;
		for (int unsigned i = 0; i < n; i++) begin
			rv = 0;
			for (int unsigned k = 0; k < l; k++)
				rv |= ((i >> k) & 1) << (l - 1 - k);
			if (i < rv) begin
				tr = frame_re[i]; ti = frame_im[i];
				frame_re[i] = frame_re[rv]; frame_im[i] = frame_im[rv];
				frame_re[rv] = tr; frame_im[rv] = ti;
			end
		end
		if (inverse)
			for (int unsigned i = 0; i < n; i++)
				frame_im[i] = clip(-frame_im[i]);
		for (int unsigned s = 1; s <= l / 2; s++) begin
			lg = 2 * s;
			le = 1 << lg;
			q  = le >> 2;
			sh = 9 - lg;
			for (int unsigned j = 0; j < q; j++) begin
				for (int unsigned i = j; i < n; i += le) begin
					r0 = frame_re[i];         i0 = frame_im[i];
					r1 = frame_re[i + q];     i1 = frame_im[i + q];
					r2 = frame_re[i + 2 * q]; i2 = frame_im[i + 2 * q];
					r3 = frame_re[i + 3 * q]; i3 = frame_im[i + 3 * q];
					rotate(r1, i1, (2 * j) << sh);
					rotate(r2, i2, j << sh);
					rotate(r3, i3, (3 * j) << sh);
					t0r = r0 + r1; t0i = i0 + i1;
					t1r = r0 - r1; t1i = i0 - i1;
					t2r = r2 + r3; t2i = i2 + i3;
					t3r = i2 - i3; t3i = r3 - r2;
					frame_re[i]         = clip(t0r + t2r); frame_im[i]         = clip(t0i + t2i);
					frame_re[i + q]     = clip(t1r + t3r); frame_im[i + q]     = clip(t1i + t3i);
					frame_re[i + 2 * q] = clip(t0r - t2r); frame_im[i + 2 * q] = clip(t0i - t2i);
					frame_re[i + 3 * q] = clip(t1r - t3r); frame_im[i + 3 * q] = clip(t1i - t3i);
				end
			end
		end
		if (l % 2 == 1) begin
			q = n >> 1;
			for (int unsigned j = 0; j < q; j++) begin
				r0 = frame_re[j];     i0 = frame_im[j];
				r1 = frame_re[j + q]; i1 = frame_im[j + q];
				rotate(r1, i1, j << (9 - l));
				frame_re[j]     = clip(r0 + r1); frame_im[j]     = clip(i0 + i1);
				frame_re[j + q] = clip(r0 - r1); frame_im[j + q] = clip(i0 - i1);
			end
		end
		if (inverse)
			for (int unsigned i = 0; i < n; i++) begin
				frame_re[i] = clip((frame_re[i] + (64'sd1 <<< (l - 1))) >>> l);
				frame_im[i] = clip((-frame_im[i] + (64'sd1 <<< (l - 1))) >>> l);
			end
	endfunction

	function void write_reg(logic idx, logic [3:0] val);
		if (idx == mrfft_pkg::REG_INVERSE) begin
			inverse = val[0];
		end else begin
			size_log2  = (val < 1) ? 1 : (val > 9) ? 9 : val;
			load_count = 0;
			bins_ready = 0;
		end
	endfunction

	function void note_request(mrfft_pkg::req_t r);
		mrfft_pkg::rsp_t e;
		int unsigned     n, b;
		n = 1 << size_log2;
		e = '0;
		if (r.mode == 1'b0) begin
			bins_ready = 0;
			frame_re[load_count] = longint'(r.sample_real);
			frame_im[load_count] = longint'(r.sample_imag);
			load_count++;
			e.status = mrfft_pkg::ST_STORED;
			if (load_count >= n) begin
				run_fft(size_log2);
				load_count = 0;
				bins_ready = 1;
				e.status   = mrfft_pkg::ST_FRAME;
			end
		end else if (!bins_ready) begin
			e.status = mrfft_pkg::ST_NONE;
		end else begin
			b          = r.bin_index & (n - 1);
			e.status   = mrfft_pkg::ST_BIN;
			e.bin_real = frame_re[b][27:0];
			e.bin_imag = frame_im[b][27:0];
		end
		expected_rsp.push_back(e);
	endfunction

	function void check_response(mrfft_pkg::rsp_t got);
		mrfft_pkg::rsp_t e;
		if (expected_rsp.size() == 0) begin
			$display("%0t: unexpected response %h", $time, got);
			errors++;
			return;
		end
		e = expected_rsp.pop_front();
		if (got.status != e.status) begin
			$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
			errors++;
		end
		if (got.bin_real != e.bin_real) begin
			$display("%0t: bin_real expected %0d actual %0d", $time, e.bin_real, got.bin_real);
			errors++;
		end
		if (got.bin_imag != e.bin_imag) begin
			$display("%0t: bin_imag expected %0d actual %0d", $time, e.bin_imag, got.bin_imag);
			errors++;
		end
	endfunction

endclass

FILE: tb/mixed_radix4_complex_fft_test.sv
// Top-level bench for mixed_radix4_complex_fft: drives frames, bin reads and register writes.
// Depends on mrfft_pkg, the DUT and the mrfft_scoreboard class.
module mixed_radix4_complex_fft_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mrfft_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_t       rsp;
	logic       cfg_we;
	logic       cfg_index;
	logic [3:0] cfg_data;

	mrfft_scoreboard fft_sb = new();
	bit  calm;        // no idling on either side once set
	int  sent;
	int  stall_left;

	mixed_radix4_complex_fft dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Hard stop: well beyond the slowest legal run, largest frames included.
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	// Response side: random stall bursts, then check every accepted transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				fft_sb.check_response(rsp);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_stall  <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 9);
				rsp_stall  <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Offer one request; hold valid and payload until the transfer happens.
	task automatic send(req_t r);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		fft_sb.note_request(r);
		sent++;
	endtask

	task automatic load(logic signed [15:0] re, logic signed [15:0] im);
		req_t r;
		r             = '0;
		r.mode        = 1'b0;
		r.sample_real = re;
		r.sample_imag = im;
		r.bin_index   = 9'($urandom_range(0, 511));
		send(r);
	endtask

	task automatic read_bin(logic [8:0] idx);
		req_t r;
		r             = '0;
		r.mode        = 1'b1;
		r.sample_real = 16'($urandom_range(0, 65535));
		r.sample_imag = 16'($urandom_range(0, 65535));
		r.bin_index   = idx;
		send(r);
	endtask

	// Drain, then write one register while the block is idle.
	task automatic write_reg(logic idx, logic [3:0] val);
		req_valid <= 1'b0;
		@(posedge clk);
		while (fft_sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		fft_sb.write_reg(idx, val);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'hffff;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int          n, reads, cut;
		logic [3:0]  code;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_INVERSE;
		cfg_data  = '0;
		calm      = 0;
		sent      = 0;
		arst_n    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: read before any frame, size clamp from zero, wrapped index,
		// a load that drops the results, then a small full-scale frame with the inverse flag cleared before its last sample.
		read_bin(9'd511);
		write_reg(REG_SIZE, 4'd0);
		load(16'sh7fff, 16'sh8000);
		load(16'sh8000, 16'sh7fff);
		read_bin(9'd0);
		read_bin(9'd1);
		read_bin(9'd511);
		load(16'sh0000, 16'sh0000);
		read_bin(9'd3);
		load(16'shffff, 16'sh0001);
		read_bin(9'd0);
		write_reg(REG_INVERSE, 4'd1);
		write_reg(REG_SIZE, 4'd2);
		load(16'sh7fff, 16'sh7fff);
		load(16'sh8000, 16'sh8000);
		load(16'sh7fff, 16'sh8000);
		// inverse flag counts only when the last sample lands
		write_reg(REG_INVERSE, 4'd0);
		load(16'sh8000, 16'sh7fff);
		for (int i = 0; i < 4; i++)
			read_bin(9'(i) | 9'h1fc);

		// Random phases: mostly small frames, one full-size frame, set to inverse unless a mid-frame write clears the flag.
		for (int p = 0; sent < 1050; p++) begin
			if (sent > 880)
				calm = 1;
			if (p == 2)
				code = 4'd15;
			else if (p % 6 == 5)
				code = 4'($urandom_range(0, 1));
			else
				code = 4'($urandom_range(1, 5));
			write_reg(REG_INVERSE, (p == 2) ? 4'd1 : 4'($urandom_range(0, 1)));
			write_reg(REG_SIZE, code);
			n = 1 << fft_sb.size_log2;
			if ($urandom_range(0, 2) == 0)
				read_bin(9'($urandom_range(0, 511)));
			for (int f = (p == 2) ? 1 : $urandom_range(1, 3); f > 0; f--) begin
				cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
				for (int i = 0; i < n; i++) begin
					if (i == cut && i > 0)
						write_reg(REG_INVERSE, 4'($urandom_range(0, 1)));
					load(pick_sample(), pick_sample());
				end
				reads = $urandom_range(1, (2 * n < 12) ? 2 * n : 12);
				repeat (reads)
					read_bin(9'($urandom_range(0, 511)));
			end
			// abandon a partial frame now and then
			if (p != 2 && n > 2 && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, n - 1))
					load(pick_sample(), pick_sample());
		end

		req_valid <= 1'b0;
		while (fft_sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fft_sb.errors == 0 && fft_sb.expected_rsp.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
